FILE: design/lcdb_pkg.sv
package lcdb_pkg;

    // request command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CTRL  = 2'd3
    } lcdb_cmd_t;

    // kind of transaction in progress
    typedef enum logic [1:0] {
        KIND_IDLE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CTRL  = 2'd3
    } lcdb_kind_t;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd10;
    localparam int         QUEUE_DEPTH_DEFAULT = 2;

    // frame lengths in phases: 3 lead-in, bit phases, 1 trailer
    localparam logic [4:0] PHASES_WRITE = 5'd30;
    localparam logic [4:0] PHASES_READ  = 5'd30;
    localparam logic [4:0] PHASES_CTRL  = 5'd28;

    // bits shifted out for each kind
    localparam logic [3:0] BITS_WRITE = 4'd13;
    localparam logic [3:0] BITS_READ  = 4'd9;
    localparam logic [3:0] BITS_CTRL  = 4'd12;

    // frame ids, left aligned in the shift word
    localparam logic [2:0] ID_WRITE = 3'b101;
    localparam logic [2:0] ID_READ  = 3'b110;
    localparam logic [2:0] ID_CTRL  = 3'b100;

    // decoded beat handed from the front to the back
    typedef struct packed {
        lcdb_cmd_t   cmd;
        logic [15:0] shift;
        logic [3:0]  bits;
        logic        pin;
    } lcdb_item_t;

endpackage

FILE: design/lcdb_if.sv
interface lcdb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] address;
    logic [7:0] payload;
    logic       data_pin_in;

    modport source (output valid, command, address, payload, data_pin_in, input ready);
    modport sink (input valid, command, address, payload, data_pin_in, output ready);
endinterface

interface lcdb_rsp_if;
    logic       valid;
    logic       ready;
    logic       chip_select;
    logic       write_strobe;
    logic       read_strobe;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [3:0] read_data;
    logic       read_valid;
    logic       rejected;

    modport source (
        output valid, chip_select, write_strobe, read_strobe, data_out, data_drive,
               busy_res, done_res, read_data, read_valid, rejected,
        input  ready
    );
    modport sink (
        input  valid, chip_select, write_strobe, read_strobe, data_out, data_drive,
               busy_res, done_res, read_data, read_valid, rejected,
        output ready
    );
endinterface

FILE: design/lcdb_front.sv
module lcdb_front (
    lcdb_req_if.sink           req,
    output logic               push_valid,
    input  logic               push_ready,
    output lcdb_pkg::lcdb_item_t push_item
);
    import lcdb_pkg::*;

    // pass handshake through to the queue
    assign push_valid = req.valid;
    assign req.ready  = push_ready;

    // build the serial frame word for each request kind
    always_comb
    begin
        push_item.cmd   = lcdb_cmd_t'(req.command);
        push_item.pin   = req.data_pin_in;
        push_item.shift = '0;
        push_item.bits  = '0;
        case (lcdb_cmd_t'(req.command))
            CMD_WRITE:
            begin
                push_item.shift = {ID_WRITE, req.address, req.payload[3:0], 3'b000};
                push_item.bits  = BITS_WRITE;
            end
            CMD_READ:
            begin
                push_item.shift = {ID_READ, req.address, 7'b0000000};
                push_item.bits  = BITS_READ;
            end
            CMD_CTRL:
            begin
                push_item.shift = {ID_CTRL, req.payload, 5'b00000};
                push_item.bits  = BITS_CTRL;
            end
            default:
            begin
                push_item.shift = '0;
                push_item.bits  = '0;
            end
        endcase
    end
endmodule

FILE: design/lcdb_fifo.sv
module lcdb_fifo #(
    parameter int DEPTH = lcdb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  lcdb_pkg::lcdb_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output lcdb_pkg::lcdb_item_t pop_item
);
    import lcdb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lcdb_item_t     mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end
endmodule

FILE: design/lcdb_back.sv
module lcdb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  lcdb_pkg::lcdb_item_t pop_item,
    lcdb_rsp_if.source           rsp
);
    import lcdb_pkg::*;

    logic [7:0]  phase_ticks_reg;
    lcdb_kind_t  kind_reg, kind_next;
    logic [4:0]  phase_reg, phase_next;
    logic [7:0]  tick_reg, tick_next;
    logic [15:0] shift_reg, shift_next;
    logic [3:0]  bits_reg, bits_next;
    logic [3:0]  acc_reg, acc_next;

    logic        out_valid_reg;
    logic        cs_reg, wr_reg, rd_reg, dout_reg, drive_reg;
    logic        busy_reg, done_reg, rvalid_reg, rej_reg;
    logic [3:0]  rdata_reg;

    lcdb_kind_t  kind_cur;
    logic [4:0]  p, total;
    logic [7:0]  t, limit;
    logic [8:0]  t_inc;
    logic [15:0] sh;
    logic [3:0]  bl, acc;
    logic        fire, last, send_ph, phase_end;
    logic        cs, wr, rd, dout, drive, busy, done, rvalid, rej;
    logic [3:0]  rdata;

    // take the next beat whenever the output slot frees up
    assign fire      = pop_valid && (!out_valid_reg || rsp.ready);
    assign pop_ready = !out_valid_reg || rsp.ready;
    assign limit     = (phase_ticks_reg == '0) ? 8'd1 : phase_ticks_reg;

    // start handling and pin levels for this tick
    always_comb
    begin
        kind_cur = kind_reg;
        p        = phase_reg;
        t        = tick_reg;
        sh       = shift_reg;
        bl       = bits_reg;
        acc      = acc_reg;
        rej      = 1'b0;
        if (pop_item.cmd != CMD_TICK)
        begin
            if (kind_reg != KIND_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                kind_cur = lcdb_kind_t'(pop_item.cmd);
                p        = '0;
                t        = '0;
                acc      = '0;
                sh       = pop_item.shift;
                bl       = pop_item.bits;
            end
        end

        case (kind_cur)
            KIND_WRITE: total = PHASES_WRITE;
            KIND_READ:  total = PHASES_READ;
            default:    total = PHASES_CTRL;
        endcase
        last = (p == total - 5'd1);

        cs        = 1'b1;
        wr        = 1'b1;
        rd        = 1'b1;
        dout      = 1'b1;
        drive     = 1'b1;
        busy      = 1'b0;
        done      = 1'b0;
        rdata     = '0;
        rvalid    = 1'b0;
        send_ph   = 1'b0;
        t_inc     = {1'b0, t} + 9'd1;
        phase_end = (t_inc >= {1'b0, limit});

        kind_next  = kind_cur;
        phase_next = p;
        tick_next  = t;
        shift_next = sh;
        bits_next  = bl;

        if (kind_cur != KIND_IDLE)
        begin
            busy = 1'b1;
            if (p == 5'd2)
            begin
                cs = 1'b0;
            end
            else if (p >= 5'd3 && !last)
            begin
                cs = 1'b0;
                if (bl != '0)
                begin
                    send_ph = 1'b1;
                    dout    = sh[15];
                    wr      = ~p[0];
                end
                else
                begin
                    drive = 1'b0;
                    dout  = 1'b0;
                    rd    = ~p[0];
                    if (rd && t == '0)
                    begin
                        acc = {acc[2:0], pop_item.pin};
                    end
                end
            end

            // phase timing
            tick_next = t_inc[7:0];
            if (phase_end)
            begin
                tick_next = '0;
                if (send_ph && !p[0])
                begin
                    shift_next = {sh[14:0], 1'b0};
                    bits_next  = bl - 4'd1;
                end
                phase_next = p + 5'd1;
                if (last)
                begin
                    done = 1'b1;
                    if (kind_cur == KIND_READ)
                    begin
                        rdata  = acc;
                        rvalid = 1'b1;
                    end
                    kind_next  = KIND_IDLE;
                    phase_next = '0;
                    bits_next  = '0;
                    shift_next = '0;
                end
            end
        end
        acc_next = acc;
    end

    // bus state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            kind_reg        <= KIND_IDLE;
            phase_reg       <= '0;
            tick_reg        <= '0;
            shift_reg       <= '0;
            bits_reg        <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_ticks_reg <= cfg_wdata;
            end
            if (fire)
            begin
                kind_reg      <= kind_next;
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                shift_reg     <= shift_next;
                bits_reg      <= bits_next;
                acc_reg       <= acc_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cs_reg     <= cs;
            wr_reg     <= wr;
            rd_reg     <= rd;
            dout_reg   <= dout;
            drive_reg  <= drive;
            busy_reg   <= busy;
            done_reg   <= done;
            rdata_reg  <= rdata;
            rvalid_reg <= rvalid;
            rej_reg    <= rej;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.chip_select  = cs_reg;
    assign rsp.write_strobe = wr_reg;
    assign rsp.read_strobe  = rd_reg;
    assign rsp.data_out     = dout_reg;
    assign rsp.data_drive   = drive_reg;
    assign rsp.busy_res     = busy_reg;
    assign rsp.done_res     = done_reg;
    assign rsp.read_data    = rdata_reg;
    assign rsp.read_valid   = rvalid_reg;
    assign rsp.rejected     = rej_reg;
endmodule

FILE: design/three_wire_lcd_bus_master.sv
// channel   dir   handshake      payload
// req       in    valid/ready    command, address, payload, data_pin_in
// rsp       out   valid/ready    pin levels, busy/done, read nibble, reject flag
// cfg       in    cfg_we         cfg_wdata -> phase_ticks
//
// one beat in per cycle, one beat out per cycle while neither side stalls; a beat is
// stored in the request queue, then the bus state update and the output register load
// on the same edge; its result is held back further while rsp is stalled
// req stalls only when the queue is full; the queue fills while rsp.ready is low
// reset clears the queue, the bus state and sets phase_ticks to 10
module three_wire_lcd_bus_master #(
    parameter int QUEUE_DEPTH = lcdb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    lcdb_req_if.sink   req,
    lcdb_rsp_if.source rsp
);
    import lcdb_pkg::*;

    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    lcdb_item_t push_item, pop_item;

    // decode requests
    lcdb_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue
    lcdb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // bus sequencer
    lcdb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .rsp       (rsp)
    );
endmodule

FILE: design/lcdb_checker.sv
module lcdb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       chip_select,
    input logic       write_strobe,
    input logic       read_strobe,
    input logic       data_out,
    input logic       data_drive,
    input logic       busy_res,
    input logic       done_res,
    input logic [3:0] read_data,
    input logic       read_valid
);
    // stalled beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(chip_select)
            && $stable(done_res) && $stable(read_data))
        else $error("rsp beat changed while stalled");

    // done only inside a transaction
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && done_res |-> busy_res)
        else $error("done without busy");

    // read nibble only with done
    a_rvalid_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_valid |-> done_res)
        else $error("read_valid without done");

    // idle bus levels
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !busy_res |-> chip_select && write_strobe && read_strobe
            && data_out && data_drive && read_data == 4'd0)
        else $error("bus not idle high while not busy");

    // released data pin only with chip select low
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !data_drive |-> !data_out && !chip_select && write_strobe)
        else $error("bad levels with data released");
endmodule

bind three_wire_lcd_bus_master lcdb_checker u_lcdb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .chip_select  (rsp.chip_select),
    .write_strobe (rsp.write_strobe),
    .read_strobe  (rsp.read_strobe),
    .data_out     (rsp.data_out),
    .data_drive   (rsp.data_drive),
    .busy_res     (rsp.busy_res),
    .done_res     (rsp.done_res),
    .read_data    (rsp.read_data),
    .read_valid   (rsp.read_valid)
);
